### sv/isotp_rx_pkg.sv
// package for the iso-tp receive tracker
// frame and result types, protocol codes and the divide-by-seven helper
// no dependencies
package isotp_rx_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int PAY_BYTES   = 7;
    localparam int OFFSET_W    = 9;
    localparam int COUNT_W     = 6;

    // protocol control codes
    localparam logic [7:0] CTL_SF_MIN   = 8'h01;
    localparam logic [7:0] CTL_SF_MAX   = 8'h07;
    localparam logic [7:0] CTL_FIRST    = 8'h10;
    localparam logic [7:0] CTL_FLOW     = 8'h30;
    localparam logic [3:0] FLOW_LEN     = 4'd3;
    localparam logic [3:0] MAX_LEN      = 4'd8;
    localparam logic [7:0] FIRST_MIN    = 8'd6;
    localparam logic [2:0] FIRST_PAY    = 3'd6;
    localparam logic [OFFSET_W-1:0] FIRST_OFFSET = 9'd6;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_FIRST = 2'd1;
    localparam logic [1:0] ST_BAD_FLOW  = 2'd2;

    typedef struct packed {
        logic [3:0]                        frame_length;
        logic [FRAME_BYTES-1:0][7:0]       data;
    } t_frame;

    typedef struct packed {
        logic                              data_valid;
        logic                              last_of_message;
        logic [1:0]                        status;
        logic [OFFSET_W-1:0]               byte_offset;
        logic [2:0]                        payload_count;
        logic [PAY_BYTES-1:0][7:0]         payload;
    } t_result;

    // x / 7 for an 8-bit x, by reciprocal 293 / 2048
    function automatic logic [COUNT_W-1:0] div7(input logic [7:0] x);
        logic [16:0] prod;
        prod = 17'(x) * 17'd293;
        return prod[16:11];
    endfunction

endpackage

### sv/isotp_rx_if.sv
// channel interfaces of the iso-tp receive tracker
// frame input channel and result output channel, valid/ready transfer
// no dependencies
interface isotp_rx_frame_if;
    logic       valid;
    logic       ready;
    logic [3:0] frame_length;
    logic [7:0] byte_0;
    logic [7:0] byte_1;
    logic [7:0] byte_2;
    logic [7:0] byte_3;
    logic [7:0] byte_4;
    logic [7:0] byte_5;
    logic [7:0] byte_6;
    logic [7:0] byte_7;

    modport source (
        output valid, frame_length, byte_0, byte_1, byte_2, byte_3,
               byte_4, byte_5, byte_6, byte_7,
        input  ready
    );
    modport sink (
        input  valid, frame_length, byte_0, byte_1, byte_2, byte_3,
               byte_4, byte_5, byte_6, byte_7,
        output ready
    );
endinterface

interface isotp_rx_result_if;
    logic       valid;
    logic       ready;
    logic       data_valid;
    logic       last_of_message;
    logic [1:0] status;
    logic [8:0] byte_offset;
    logic [2:0] payload_count;
    logic [7:0] payload_0;
    logic [7:0] payload_1;
    logic [7:0] payload_2;
    logic [7:0] payload_3;
    logic [7:0] payload_4;
    logic [7:0] payload_5;
    logic [7:0] payload_6;

    modport source (
        output valid, data_valid, last_of_message, status, byte_offset,
               payload_count, payload_0, payload_1, payload_2, payload_3,
               payload_4, payload_5, payload_6,
        input  ready
    );
    modport sink (
        input  valid, data_valid, last_of_message, status, byte_offset,
               payload_count, payload_0, payload_1, payload_2, payload_3,
               payload_4, payload_5, payload_6,
        output ready
    );
endinterface

### sv/isotp_rx_core.sv
// transfer tracking state machine and result register; updates
// phase, counters; one registered frame per cycle unless stalled
// depends on isotp_rx_pkg
module isotp_rx_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_frame_valid,
    input  isotp_rx_pkg::t_frame   i_frame,
    input  logic                   i_res_ready,
    output logic                   o_advance,
    output logic                   o_res_valid,
    output isotp_rx_pkg::t_result  o_res
);
    import isotp_rx_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_WAIT_FC = 2'd1,
        PH_CF      = 2'd2
    } t_phase;

    t_phase               r_phase, n_phase;
    logic [COUNT_W-1:0]   r_frames_remaining, n_frames_remaining;
    logic [OFFSET_W-1:0]  r_write_offset, n_write_offset;
    logic                 r_res_valid;
    t_result              r_res, n_res;

    logic [3:0]           len_clip;
    logic [2:0]           tail;
    logic [7:0]           ctl;
    logic [7:0]           mlen;
    logic                 load;
    logic [PAY_BYTES-1:0][7:0] tail_pay;
    logic [PAY_BYTES-1:0][7:0] first_pay;

    assign o_advance = !r_res_valid || i_res_ready;
    assign load      = i_frame_valid && o_advance;
    assign ctl       = i_frame.data[0];
    assign mlen      = i_frame.data[1];
    assign len_clip  = (i_frame.frame_length > MAX_LEN) ? MAX_LEN : i_frame.frame_length;
    assign tail      = (len_clip == 4'd0) ? 3'd0 : 3'(len_clip - 4'd1);

    always_comb begin
        for (int k = 0; k < PAY_BYTES; k++) begin
            tail_pay[k]  = (3'(k) < tail) ? i_frame.data[k + 1] : 8'h00;
            first_pay[k] = (3'(k) < FIRST_PAY) ? i_frame.data[(k + 2) % FRAME_BYTES] : 8'h00;
        end
    end

    always_comb begin
        n_phase            = r_phase;
        n_frames_remaining = r_frames_remaining;
        n_write_offset     = r_write_offset;
        n_res              = '0;
        if (r_phase == PH_WAIT_FC) begin
            if (ctl == CTL_FLOW && i_frame.frame_length == FLOW_LEN) begin
                n_phase = PH_CF;
            end else begin
                n_res.status       = ST_BAD_FLOW;
                n_phase            = PH_IDLE;
                n_frames_remaining = '0;
                n_write_offset     = '0;
            end
        end else if (r_phase == PH_CF && r_frames_remaining != '0) begin
            n_res.data_valid    = 1'b1;
            n_res.payload_count = tail;
            n_res.payload       = tail_pay;
            n_res.byte_offset   = r_write_offset;
            n_write_offset      = r_write_offset + OFFSET_W'(tail);
            n_frames_remaining  = r_frames_remaining - COUNT_W'(1);
            if (r_frames_remaining == COUNT_W'(1)) begin
                n_res.last_of_message = 1'b1;
                n_phase               = PH_IDLE;
                n_write_offset        = '0;
            end
        end else begin
            n_phase            = PH_IDLE;
            n_frames_remaining = '0;
            n_write_offset     = '0;
            if (ctl >= CTL_SF_MIN && ctl <= CTL_SF_MAX) begin
                n_res.data_valid      = 1'b1;
                n_res.last_of_message = 1'b1;
                n_res.payload_count   = tail;
                n_res.payload         = tail_pay;
            end else if (ctl == CTL_FIRST) begin
                if (mlen <= FIRST_MIN) begin
                    n_res.status = ST_BAD_FIRST;
                end else begin
                    n_res.data_valid    = 1'b1;
                    n_res.payload_count = FIRST_PAY;
                    n_res.payload       = first_pay;
                    n_frames_remaining  = div7(mlen);
                    n_write_offset      = FIRST_OFFSET;
                    n_phase             = PH_WAIT_FC;
                end
            end else begin
                n_res.status = ST_BAD_FIRST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase            <= PH_IDLE;
            r_frames_remaining <= '0;
            r_write_offset     <= '0;
            r_res_valid        <= 1'b0;
        end else begin
            if (load) begin
                r_phase            <= n_phase;
                r_frames_remaining <= n_frames_remaining;
                r_write_offset     <= n_write_offset;
                r_res_valid        <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid        <= 1'b0;
            end
        end
        if (load) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

### sv/isotp_receive_tracker_top.sv
// iso-tp receive tracker: one result per frame;
// one frame per cycle sustained while the result output is not stalled, set by the state update in isotp_rx_core
// input register, then the state machine and its result register
// synchronous active-low reset clears phase, frame count, offset and both valid flags
// depends on isotp_rx_pkg, isotp_rx_if and isotp_rx_core
module isotp_receive_tracker_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    isotp_rx_frame_if.sink   i_frame,
    isotp_rx_result_if.source o_result
);
    import isotp_rx_pkg::*;

    logic    r_in_valid;
    t_frame  r_frame;
    t_frame  n_frame;
    logic    advance;
    logic    res_valid;
    t_result res;

    assign i_frame.ready = !r_in_valid || advance;

    always_comb begin
        n_frame.frame_length = i_frame.frame_length;
        n_frame.data[0]      = i_frame.byte_0;
        n_frame.data[1]      = i_frame.byte_1;
        n_frame.data[2]      = i_frame.byte_2;
        n_frame.data[3]      = i_frame.byte_3;
        n_frame.data[4]      = i_frame.byte_4;
        n_frame.data[5]      = i_frame.byte_5;
        n_frame.data[6]      = i_frame.byte_6;
        n_frame.data[7]      = i_frame.byte_7;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_frame.ready) begin
            r_in_valid <= i_frame.valid;
        end
        if (i_frame.ready && i_frame.valid) begin
            r_frame <= n_frame;
        end
    end

    isotp_rx_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_valid (r_in_valid),
        .i_frame       (r_frame),
        .i_res_ready   (o_result.ready),
        .o_advance     (advance),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    assign o_result.valid           = res_valid;
    assign o_result.data_valid      = res.data_valid;
    assign o_result.last_of_message = res.last_of_message;
    assign o_result.status          = res.status;
    assign o_result.byte_offset     = res.byte_offset;
    assign o_result.payload_count   = res.payload_count;
    assign o_result.payload_0       = res.payload[0];
    assign o_result.payload_1       = res.payload[1];
    assign o_result.payload_2       = res.payload[2];
    assign o_result.payload_3       = res.payload[3];
    assign o_result.payload_4       = res.payload[4];
    assign o_result.payload_5       = res.payload[5];
    assign o_result.payload_6       = res.payload[6];

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// self-checking bench for isotp_receive_tracker_top: a directed frame table, then random
// iso-tp traffic under varying idle and stall, each result checked against the table or a local tracker
// depends on isotp_rx_pkg, isotp_rx_if and the tracker rtl
module testbench;
    import isotp_rx_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int N_DIR        = 22;
    localparam int PHASE_ITEMS  = 300;
    localparam int BURST_ITEMS  = 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int SRC_IDLE [4] = '{0, 49, 0, 18};
    localparam int SNK_STALL [4] = '{0, 0, 49, 18};
    localparam logic [7:0] CTL_CONSEC = 8'h20;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_WAIT_FLOW = 2'd1,
        PH_CONSEC    = 2'd2
    } t_rx_phase;

    typedef struct {
        t_frame  frame;
        bit      typed;
        t_result want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    isotp_rx_frame_if  frame_ch ();
    isotp_rx_result_if result_ch ();

    isotp_receive_tracker_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_ch),
        .o_result (result_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // tracker state
    t_rx_phase  rx_phase;
    logic [5:0] frames_left;
    logic [8:0] next_offset;

    t_result expected_results [$];
    int failures = 0;
    int frames_sent = 0;
    int results_checked = 0;
    int messages_done = 0;
    int bad_first_seen = 0;
    int bad_flow_seen = 0;
    int quiet_cycles = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_left = 0;
    bit hold_request = 1'b0;

    function automatic t_result plain_result(logic valid, logic last, logic [1:0] status);
        t_result r;
        r = '0;
        r.data_valid = valid;
        r.last_of_message = last;
        r.status = status;
        return r;
    endfunction

    t_dir_row dir_rows [N_DIR] = '{
        '{'{4'd0,  64'hFFFF_FFFF_FFFF_FF01}, 1'b1, plain_result(1'b1, 1'b1, ST_OK)},
        '{'{4'd8,  64'hFFFE_FDFC_FBFA_F907}, 1'b0, '0},
        '{'{4'd15, 64'h7766_5544_3322_1103}, 1'b0, '0},
        '{'{4'd1,  64'hAAAA_AAAA_AAAA_AA01}, 1'b1, plain_result(1'b1, 1'b1, ST_OK)},
        '{'{4'd8,  64'h0000_0000_0000_0000}, 1'b1, plain_result(1'b0, 1'b0, ST_BAD_FIRST)},
        '{'{4'd8,  64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, plain_result(1'b0, 1'b0, ST_BAD_FIRST)},
        '{'{4'd8,  64'h5555_5555_5555_5508}, 1'b1, plain_result(1'b0, 1'b0, ST_BAD_FIRST)},
        '{'{4'd8,  64'h0102_0304_0506_0610}, 1'b1, plain_result(1'b0, 1'b0, ST_BAD_FIRST)},
        '{'{4'd8,  64'hFFFF_FFFF_FFFF_0010}, 1'b1, plain_result(1'b0, 1'b0, ST_BAD_FIRST)},
        '{'{4'd8,  64'h6655_4433_2211_0710}, 1'b0, '0},
        '{'{4'd4,  64'h0000_0000_0000_0030}, 1'b1, plain_result(1'b0, 1'b0, ST_BAD_FLOW)},
        '{'{4'd8,  64'h8080_8080_8080_0710}, 1'b0, '0},
        '{'{4'd3,  64'h0000_0000_0000_0031}, 1'b1, plain_result(1'b0, 1'b0, ST_BAD_FLOW)},
        '{'{4'd8,  64'hA5A5_A5A5_A5A5_1410}, 1'b0, '0},
        '{'{4'd3,  64'h0000_0000_0000_0030}, 1'b1, plain_result(1'b0, 1'b0, ST_OK)},
        '{'{4'd8,  64'h0F1E_2D3C_4B5A_6921}, 1'b0, '0},
        '{'{4'd0,  64'h1234_5678_9ABC_DE10}, 1'b0, '0},
        '{'{4'd3,  64'h0000_0000_0000_0030}, 1'b1, plain_result(1'b0, 1'b0, ST_BAD_FIRST)},
        '{'{4'd8,  64'hC3C3_C3C3_C3C3_FF10}, 1'b0, '0},
        '{'{4'd3,  64'hFFFF_FFFF_FF00_0030}, 1'b1, plain_result(1'b0, 1'b0, ST_OK)},
        '{'{4'd9,  64'hEEDD_CCBB_AA99_8821}, 1'b0, '0},
        '{'{4'd6,  64'h0102_0304_0506_0705}, 1'b0, '0}
    };

    function automatic void clear_tracking();
        rx_phase = PH_IDLE;
        frames_left = '0;
        next_offset = '0;
    endfunction

    function automatic t_result track_frame(t_frame f);
        t_result r;
        logic [7:0] ctl;
        int tail;
        r = '0;
        ctl = f.data[0];
        tail = (f.frame_length == 0) ? 0
             : ((f.frame_length > MAX_LEN) ? int'(MAX_LEN) : int'(f.frame_length)) - 1;

        if (rx_phase == PH_WAIT_FLOW) begin
            if (ctl == CTL_FLOW && f.frame_length == FLOW_LEN) begin
                rx_phase = PH_CONSEC;
            end else begin
                r.status = ST_BAD_FLOW;
                clear_tracking();
            end
            return r;
        end

        if (rx_phase == PH_CONSEC && frames_left != 0) begin
            for (int k = 0; k < tail; k++) r.payload[k] = f.data[k + 1];
            r.data_valid = 1'b1;
            r.payload_count = 3'(tail);
            r.byte_offset = next_offset;
            next_offset = next_offset + 9'(tail);
            frames_left = frames_left - 6'd1;
            if (frames_left == 0) begin
                r.last_of_message = 1'b1;
                clear_tracking();
            end
            return r;
        end

        clear_tracking();
        if (ctl >= CTL_SF_MIN && ctl <= CTL_SF_MAX) begin
            for (int k = 0; k < tail; k++) r.payload[k] = f.data[k + 1];
            r.data_valid = 1'b1;
            r.payload_count = 3'(tail);
            r.last_of_message = 1'b1;
        end else if (ctl == CTL_FIRST) begin
            if (f.data[1] <= FIRST_MIN) begin
                r.status = ST_BAD_FIRST;
            end else begin
                for (int k = 0; k < int'(FIRST_PAY); k++) r.payload[k] = f.data[k + 2];
                r.data_valid = 1'b1;
                r.payload_count = FIRST_PAY;
                // ceil((len - 6) / 7) consecutive frames
                frames_left = 6'((int'(f.data[1]) - int'(FIRST_MIN) + 6) / 7);
                next_offset = FIRST_OFFSET;
                rx_phase = PH_WAIT_FLOW;
            end
        end else begin
            r.status = ST_BAD_FIRST;
        end
        return r;
    endfunction

    function automatic t_frame make_frame(int len, int ctl);
        t_frame f;
        f.frame_length = 4'(len);
        for (int k = 1; k < FRAME_BYTES; k++) f.data[k] = 8'($urandom);
        f.data[0] = 8'(ctl);
        return f;
    endfunction

    task automatic send_frame(t_frame f, bit typed = 1'b0, t_result want = '0);
        t_result predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            frame_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        frame_ch.valid = 1'b1;
        frame_ch.frame_length = f.frame_length;
        frame_ch.byte_0 = f.data[0];
        frame_ch.byte_1 = f.data[1];
        frame_ch.byte_2 = f.data[2];
        frame_ch.byte_3 = f.data[3];
        frame_ch.byte_4 = f.data[4];
        frame_ch.byte_5 = f.data[5];
        frame_ch.byte_6 = f.data[6];
        frame_ch.byte_7 = f.data[7];
        @(posedge i_clk);
        while (!frame_ch.ready) @(posedge i_clk);
        predicted = track_frame(f);
        expected_results.push_back(typed ? want : predicted);
        frames_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        frame_ch.valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // mostly well-formed messages with random content, some broken ones and noise
    task automatic send_random_message();
        int pick;
        int mlen;
        int left;
        int n;
        int cfs;
        t_frame f;
        pick = $urandom_range(99);
        if (pick < 30) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 8);
            send_frame(make_frame(n, $urandom_range(int'(CTL_SF_MIN), int'(CTL_SF_MAX))));
        end else if (pick < 85) begin
            pick = $urandom_range(99);
            mlen = (pick < 80) ? $urandom_range(7, 40)
                 : (pick < 95) ? $urandom_range(41, 120) : $urandom_range(121, 255);
            f = make_frame(($urandom_range(99) < 90) ? 8 : $urandom_range(15),
                           int'(CTL_FIRST));
            f.data[1] = 8'(mlen);
            send_frame(f);
            if ($urandom_range(99) < 8) begin
                send_frame(make_frame($urandom_range(15),
                                      $urandom_range(1) ? int'(CTL_FLOW)
                                                        : int'($urandom_range(255))));
                return;
            end
            send_frame(make_frame(int'(FLOW_LEN), int'(CTL_FLOW)));
            left = mlen - int'(FIRST_PAY);
            cfs = (left + 6) / 7;
            for (int i = 0; i < cfs; i++) begin
                // abandoned message
                if ($urandom_range(99) < 3) return;
                n = (left > 7) ? 7 : left;
                left -= n;
                if ($urandom_range(99) < 10)
                    f = make_frame($urandom_range(15), $urandom_range(255));
                else
                    f = make_frame(n + 1, int'(CTL_CONSEC) | ((i + 1) & 15));
                send_frame(f);
            end
        end else begin
            send_frame(make_frame($urandom_range(15), $urandom_range(255)));
        end
    endtask

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            result_ch.ready = 1'b0;
            hold_left--;
        end else begin
            result_ch.ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected");
                failures++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                compare_field("data_valid", 32'(want.data_valid), 32'(result_ch.data_valid));
                compare_field("last_of_message", 32'(want.last_of_message),
                              32'(result_ch.last_of_message));
                compare_field("status", 32'(want.status), 32'(result_ch.status));
                compare_field("byte_offset", 32'(want.byte_offset),
                              32'(result_ch.byte_offset));
                compare_field("payload_count", 32'(want.payload_count),
                              32'(result_ch.payload_count));
                compare_field("payload_0", 32'(want.payload[0]), 32'(result_ch.payload_0));
                compare_field("payload_1", 32'(want.payload[1]), 32'(result_ch.payload_1));
                compare_field("payload_2", 32'(want.payload[2]), 32'(result_ch.payload_2));
                compare_field("payload_3", 32'(want.payload[3]), 32'(result_ch.payload_3));
                compare_field("payload_4", 32'(want.payload[4]), 32'(result_ch.payload_4));
                compare_field("payload_5", 32'(want.payload[5]), 32'(result_ch.payload_5));
                compare_field("payload_6", 32'(want.payload[6]), 32'(result_ch.payload_6));
                if (want.last_of_message) messages_done++;
                if (want.status == ST_BAD_FIRST) bad_first_seen++;
                if (want.status == ST_BAD_FLOW) bad_flow_seen++;
            end
        end
        if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("no transfer for %0d cycles, giving up", QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int phase_start;
        frame_ch.valid = 1'b0;
        frame_ch.frame_length = '0;
        frame_ch.byte_0 = '0;
        frame_ch.byte_1 = '0;
        frame_ch.byte_2 = '0;
        frame_ch.byte_3 = '0;
        frame_ch.byte_4 = '0;
        frame_ch.byte_5 = '0;
        frame_ch.byte_6 = '0;
        frame_ch.byte_7 = '0;
        result_ch.ready = 1'b0;
        clear_tracking();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < N_DIR; i++)
            send_frame(dir_rows[i].frame, dir_rows[i].typed, dir_rows[i].want);
        drain_results();

        // long output hold while frames keep coming, to back up the pipeline
        hold_request = 1'b1;
        phase_start = frames_sent;
        while (frames_sent - phase_start < BURST_ITEMS) send_random_message();
        drain_results();

        for (int p = 0; p < 4; p++) begin
            src_idle_pct = SRC_IDLE[p];
            sink_stall_pct = SNK_STALL[p];
            phase_start = frames_sent;
            while (frames_sent - phase_start < PHASE_ITEMS) send_random_message();
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d frames, checked %0d results", frames_sent, results_checked);
        $display("%0d completed messages, %0d bad first/unknown frames, %0d bad flow controls",
                 messages_done, bad_first_seen, bad_flow_seen);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
